// ----- rtl/jtw_pkg.sv -----
// Shared types, codes and character constants for the JSON token writer.
`timescale 1ns / 1ps

package jtw_pkg;

  // Token codes carried on the action field
  typedef enum logic [3:0] {
    ACT_OBJ_OPEN  = 4'd0,
    ACT_OBJ_CLOSE = 4'd1,
    ACT_ARR_OPEN  = 4'd2,
    ACT_ARR_CLOSE = 4'd3,
    ACT_STR_OPEN  = 4'd4,
    ACT_STR_CHAR  = 4'd5,
    ACT_STR_CLOSE = 4'd6,
    ACT_KEY_CLOSE = 4'd7,
    ACT_NULL      = 4'd8,
    ACT_BOOL      = 4'd9,
    ACT_UINT      = 4'd10,
    ACT_INT       = 4'd11
  } action_e;

  // Front-end sequencer states
  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MUL,
    FR_CONV,
    FR_PUSH
  } fr_state_e;

  localparam int unsigned TextBytes = 5;
  localparam int unsigned NumDigits = 10;

  // Text bytes
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LOW_T   = 8'h74;
  localparam logic [7:0] CH_LOW_N   = 8'h6E;
  localparam logic [7:0] CH_LOW_F   = 8'h66;
  localparam logic [7:0] CH_LOW_R   = 8'h72;
  localparam logic [7:0] CH_LOW_U   = 8'h75;
  localparam logic [7:0] CH_LOW_L   = 8'h6C;
  localparam logic [7:0] CH_LOW_E   = 8'h65;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_S   = 8'h73;

  // Reciprocal of ten: floor(x / 10) = (x * RECIP10) >> RECIP_SHIFT for 32-bit x
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam logic [3:0]  RADIX       = 4'd10;

  // One queued command: optional comma, literal text, then decimal digits
  typedef struct packed {
    logic                              comma;
    logic [TextBytes-1:0][7:0]         text;
    logic [$clog2(TextBytes+1)-1:0]    tlen;
    logic [NumDigits-1:0][3:0]         digits;
    logic [$clog2(NumDigits+1)-1:0]    dlen;
  } cmd_t;

endpackage

// ----- rtl/jtw_front.sv -----
// Front end: accepts tokens, tracks the comma flag, converts integers to digits.
`timescale 1ns / 1ps

module jtw_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [3:0]       action_i,
  input  logic [31:0]      value_i,
  output logic             push_o,
  output jtw_pkg::cmd_t    cmd_o,
  input  logic             full_i
);

  localparam int unsigned DCntW = $clog2(jtw_pkg::NumDigits + 1);

  jtw_pkg::fr_state_e state_q, state_d;
  logic               comma_q, comma_d;
  logic [31:0]        prev_q, prev_d;
  logic [31:0]        cur_q, cur_d;
  logic [jtw_pkg::NumDigits-1:0][3:0] digits_q, digits_d;
  logic [DCntW-1:0]   dcnt_q, dcnt_d;
  logic               icomma_q, icomma_d;
  logic               neg_q, neg_d;

  logic               in_fire;
  logic               is_int;
  logic               simple_ok;
  jtw_pkg::cmd_t      simple_cmd;
  logic               simple_comma_next;
  logic [31:0]        mul_in;
  logic [63:0]        prod;
  logic [31:0]        quot;
  logic [31:0]        rem;
  logic [3:0]         digit;
  logic [7:0]         chr;
  jtw_pkg::cmd_t      int_cmd;

  // Accept only while idle and the queue has room
  assign in_stall_o = (state_q != jtw_pkg::FR_IDLE) || full_i;

  assign in_fire = in_valid_i && !in_stall_o;
  assign is_int  = (jtw_pkg::action_e'(action_i) == jtw_pkg::ACT_UINT) ||
                   (jtw_pkg::action_e'(action_i) == jtw_pkg::ACT_INT);
  assign chr     = value_i[7:0];

  // Shared divide-by-ten through the reciprocal multiply
  assign mul_in = (state_q == jtw_pkg::FR_MUL) ? prev_q : cur_q;
  assign prod   = 64'(mul_in) * 64'(jtw_pkg::RECIP10);
  assign quot   = 32'(prod >> jtw_pkg::RECIP_SHIFT);

  // Remainder of the previous dividend against its registered quotient
  assign rem   = prev_q - ((cur_q << 3) + (cur_q << 1));
  assign digit = rem[3:0];

  // Build the command for tokens that need no conversion
  always_comb begin
    simple_cmd        = '0;
    simple_ok         = 1'b1;
    simple_comma_next = comma_q;
    case (jtw_pkg::action_e'(action_i))
      jtw_pkg::ACT_OBJ_OPEN: begin
        simple_cmd.comma   = comma_q;
        simple_cmd.text[0] = jtw_pkg::CH_LBRACE;
        simple_cmd.tlen    = 3'd1;
        simple_comma_next  = 1'b0;
      end
      jtw_pkg::ACT_OBJ_CLOSE: begin
        simple_cmd.text[0] = jtw_pkg::CH_RBRACE;
        simple_cmd.tlen    = 3'd1;
        simple_comma_next  = 1'b1;
      end
      jtw_pkg::ACT_ARR_OPEN: begin
        simple_cmd.comma   = comma_q;
        simple_cmd.text[0] = jtw_pkg::CH_LBRACK;
        simple_cmd.tlen    = 3'd1;
        simple_comma_next  = 1'b0;
      end
      jtw_pkg::ACT_ARR_CLOSE: begin
        simple_cmd.text[0] = jtw_pkg::CH_RBRACK;
        simple_cmd.tlen    = 3'd1;
        simple_comma_next  = 1'b1;
      end
      jtw_pkg::ACT_STR_OPEN: begin
        simple_cmd.comma   = comma_q;
        simple_cmd.text[0] = jtw_pkg::CH_QUOTE;
        simple_cmd.tlen    = 3'd1;
        simple_comma_next  = 1'b1;
      end
      jtw_pkg::ACT_STR_CHAR: begin
        // Escape tab, form feed, carriage return, newline, backslash and quote
        simple_cmd.text[0] = jtw_pkg::CH_BSLASH;
        simple_cmd.tlen    = 3'd2;
        case (chr)
          jtw_pkg::CH_TAB:    simple_cmd.text[1] = jtw_pkg::CH_LOW_T;
          jtw_pkg::CH_FF:     simple_cmd.text[1] = jtw_pkg::CH_LOW_F;
          jtw_pkg::CH_CR:     simple_cmd.text[1] = jtw_pkg::CH_LOW_R;
          jtw_pkg::CH_NL:     simple_cmd.text[1] = jtw_pkg::CH_LOW_N;
          jtw_pkg::CH_BSLASH: simple_cmd.text[1] = chr;
          jtw_pkg::CH_QUOTE:  simple_cmd.text[1] = chr;
          default: begin
            simple_cmd.text[0] = chr;
            simple_cmd.tlen    = 3'd1;
          end
        endcase
      end
      jtw_pkg::ACT_STR_CLOSE: begin
        simple_cmd.text[0] = jtw_pkg::CH_QUOTE;
        simple_cmd.tlen    = 3'd1;
      end
      jtw_pkg::ACT_KEY_CLOSE: begin
        simple_cmd.text[0] = jtw_pkg::CH_QUOTE;
        simple_cmd.text[1] = jtw_pkg::CH_COLON;
        simple_cmd.tlen    = 3'd2;
        simple_comma_next  = 1'b0;
      end
      jtw_pkg::ACT_NULL: begin
        simple_cmd.comma   = comma_q;
        simple_cmd.text[0] = jtw_pkg::CH_LOW_N;
        simple_cmd.text[1] = jtw_pkg::CH_LOW_U;
        simple_cmd.text[2] = jtw_pkg::CH_LOW_L;
        simple_cmd.text[3] = jtw_pkg::CH_LOW_L;
        simple_cmd.tlen    = 3'd4;
        simple_comma_next  = 1'b1;
      end
      jtw_pkg::ACT_BOOL: begin
        simple_cmd.comma  = comma_q;
        simple_comma_next = 1'b1;
        if (value_i[0]) begin
          simple_cmd.text[0] = jtw_pkg::CH_LOW_T;
          simple_cmd.text[1] = jtw_pkg::CH_LOW_R;
          simple_cmd.text[2] = jtw_pkg::CH_LOW_U;
          simple_cmd.text[3] = jtw_pkg::CH_LOW_E;
          simple_cmd.tlen    = 3'd4;
        end else begin
          simple_cmd.text[0] = jtw_pkg::CH_LOW_F;
          simple_cmd.text[1] = jtw_pkg::CH_LOW_A;
          simple_cmd.text[2] = jtw_pkg::CH_LOW_L;
          simple_cmd.text[3] = jtw_pkg::CH_LOW_S;
          simple_cmd.text[4] = jtw_pkg::CH_LOW_E;
          simple_cmd.tlen    = 3'd5;
        end
      end
      default: begin
        // Integers take the conversion path; unused codes emit nothing
        simple_ok = 1'b0;
      end
    endcase
  end

  // Assemble the command for a converted integer
  always_comb begin
    int_cmd         = '0;
    int_cmd.comma   = icomma_q;
    int_cmd.text[0] = jtw_pkg::CH_MINUS;
    int_cmd.tlen    = neg_q ? 3'd1 : 3'd0;
    int_cmd.digits  = digits_q;
    int_cmd.dlen    = dcnt_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      jtw_pkg::FR_IDLE: begin
        if (in_fire && is_int) state_d = jtw_pkg::FR_MUL;
      end
      jtw_pkg::FR_MUL: begin
        state_d = jtw_pkg::FR_CONV;
      end
      jtw_pkg::FR_CONV: begin
        if ((cur_q == '0) || (dcnt_q == DCntW'(jtw_pkg::NumDigits - 1))) begin
          state_d = jtw_pkg::FR_PUSH;
        end
      end
      jtw_pkg::FR_PUSH: begin
        if (!full_i) state_d = jtw_pkg::FR_IDLE;
      end
      default: state_d = jtw_pkg::FR_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    push_o     = 1'b0;
    cmd_o      = int_cmd;
    comma_d    = comma_q;
    prev_d     = prev_q;
    cur_d      = cur_q;
    digits_d   = digits_q;
    dcnt_d     = dcnt_q;
    icomma_d   = icomma_q;
    neg_d      = neg_q;
    case (state_q)
      jtw_pkg::FR_IDLE: begin
        cmd_o      = simple_cmd;
        if (in_fire) begin
          if (is_int) begin
            // Latch the magnitude and the comma decision
            neg_d    = (jtw_pkg::action_e'(action_i) == jtw_pkg::ACT_INT) && value_i[31];
            prev_d   = neg_d ? (32'd0 - value_i) : value_i;
            icomma_d = comma_q;
            comma_d  = 1'b1;
          end else if (simple_ok) begin
            push_o  = 1'b1;
            comma_d = simple_comma_next;
          end
        end
      end
      jtw_pkg::FR_MUL: begin
        cur_d  = quot;
        dcnt_d = '0;
      end
      jtw_pkg::FR_CONV: begin
        // Store one digit, most significant ends up at index zero
        digits_d = {digits_q[jtw_pkg::NumDigits-2:0], digit};
        dcnt_d   = dcnt_q + 1'b1;
        prev_d   = cur_q;
        cur_d    = quot;
      end
      jtw_pkg::FR_PUSH: begin
        push_o = !full_i;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jtw_pkg::FR_IDLE;
      comma_q <= 1'b0;
    end else begin
      state_q <= state_d;
      comma_q <= comma_d;
    end
  end

  // Conversion registers
  always_ff @(posedge clk_i) begin
    prev_q   <= prev_d;
    cur_q    <= cur_d;
    digits_q <= digits_d;
    dcnt_q   <= dcnt_d;
    icomma_q <= icomma_d;
    neg_q    <= neg_d;
  end

endmodule

// ----- rtl/jtw_queue.sv -----
// Two-entry command queue between the front end and the byte emitter.
`timescale 1ns / 1ps

module jtw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jtw_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output jtw_pkg::cmd_t head_o,
  output logic          head_valid_o
);

  jtw_pkg::cmd_t head_q, head_d;
  jtw_pkg::cmd_t tail_q, tail_d;
  logic          head_vld_q, head_vld_d;
  logic          tail_vld_q, tail_vld_d;

  assign full_o       = tail_vld_q;
  assign head_o       = head_q;
  assign head_valid_o = head_vld_q;

  // Move entries toward the head on pop, fill the first free slot on push
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    head_vld_d = head_vld_q;
    tail_vld_d = tail_vld_q;
    if (pop_i) begin
      head_d     = tail_q;
      head_vld_d = tail_vld_q;
      tail_vld_d = 1'b0;
      if (push_i) begin
        if (tail_vld_q) begin
          tail_d     = push_cmd_i;
          tail_vld_d = 1'b1;
        end else begin
          head_d     = push_cmd_i;
          head_vld_d = 1'b1;
        end
      end
    end else if (push_i) begin
      if (!head_vld_q) begin
        head_d     = push_cmd_i;
        head_vld_d = 1'b1;
      end else begin
        tail_d     = push_cmd_i;
        tail_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      tail_vld_q <= tail_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

// ----- rtl/jtw_back.sv -----
// Back end: emits a command a byte per cycle unless stalled, counts bytes.
`timescale 1ns / 1ps

module jtw_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  jtw_pkg::cmd_t head_i,
  input  logic          head_valid_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          last_o,
  output logic [31:0]   bytes_written_o
);

  jtw_pkg::cmd_t cmd_q, cmd_d;
  logic          busy;
  logic          out_fire;
  logic [31:0]   cnt_q;

  assign busy     = cmd_q.comma || (cmd_q.tlen != '0) || (cmd_q.dlen != '0);
  assign out_fire = busy && !out_stall_i;

  assign out_valid_o     = busy;
  assign bytes_written_o = cnt_q;

  // Pick the current byte: comma, then text, then digits
  always_comb begin
    if (cmd_q.comma) begin
      out_byte_o = jtw_pkg::CH_COMMA;
    end else if (cmd_q.tlen != '0) begin
      out_byte_o = cmd_q.text[0];
    end else begin
      out_byte_o = jtw_pkg::CH_ZERO + {4'd0, cmd_q.digits[0]};
    end
  end

  assign last_o = !cmd_q.comma &&
                  (((cmd_q.tlen == 3'd1) && (cmd_q.dlen == '0)) ||
                   ((cmd_q.tlen == '0) && (cmd_q.dlen == 4'd1)));

  // Load the next command as the current one finishes
  assign pop_o = head_valid_i && (!busy || (out_fire && last_o));

  // Advance through the current command
  always_comb begin
    cmd_d = cmd_q;
    if (pop_o) begin
      cmd_d = head_i;
    end else if (out_fire) begin
      if (cmd_q.comma) begin
        cmd_d.comma = 1'b0;
      end else if (cmd_q.tlen != '0) begin
        cmd_d.text = cmd_q.text >> 8;
        cmd_d.tlen = cmd_q.tlen - 1'b1;
      end else begin
        cmd_d.digits = cmd_q.digits >> 4;
        cmd_d.dlen   = cmd_q.dlen - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0;
      cnt_q <= 32'd1;
    end else begin
      cmd_q <= cmd_d;
      if (out_fire) cnt_q <= cnt_q + 32'd1;
    end
  end

endmodule

// ----- rtl/json_token_writer_unit.sv -----
// Top level of the JSON token writer: front end, command queue and byte emitter.
`timescale 1ns / 1ps

// Takes JSON tokens on the input channel and emits their text one byte per
// item on the output channel, with last marking a token's final byte and
// bytes_written giving the running byte count including that byte.
// Non-integer tokens are classified and queued in the cycle they are
// accepted. An integer token holds the input for its decimal conversion,
// one digit per cycle through a reciprocal multiply, as the front end steps
// through its MUL, CONV and PUSH states. A two-entry queue lets conversion
// of the next token overlap with emission of the previous one, so the
// sustained rate is set by the slower of the two: the front end's conversion
// or the emitter's playout of each command's bytes.
module json_token_writer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  action_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic [31:0] bytes_written_o
);

  logic          push;
  jtw_pkg::cmd_t push_cmd;
  logic          full;
  logic          pop;
  jtw_pkg::cmd_t head;
  logic          head_valid;

  jtw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .value_i    (value_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  jtw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  jtw_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .head_valid_i    (head_valid),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .last_o          (last_o),
    .bytes_written_o (bytes_written_o)
  );

endmodule
